### rtl/core/feedback_comb_filter_unit_assert.svh
// ----------------------------------------------------------------------------
// Feedback comb filter assertion macros
// Clocked implication checks shared by the block's checker.
// ----------------------------------------------------------------------------
`ifndef FEEDBACK_COMB_FILTER_UNIT_ASSERT_SVH
`define FEEDBACK_COMB_FILTER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define FCF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fcf check failed");

// Next-cycle implication, disabled while reset is held.
`define FCF_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fcf check failed");

`endif

### rtl/core/fcf_pkg.sv
// ----------------------------------------------------------------------------
// fcf_pkg
// Widths, constants and shared types of the feedback comb filter.
// ----------------------------------------------------------------------------
package fcf_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int GAIN_W      = 15;
    localparam int DELAY_W     = 13;
    localparam int MAX_DELAY   = 4096;
    localparam int PTR_W       = $clog2(MAX_DELAY);
    localparam int GAIN_SHIFT  = 15;
    localparam int GAIN_ONE    = 1 << GAIN_SHIFT;
    localparam int PROD_W      = SAMPLE_W + GAIN_W + 2;
    localparam int ACC_W       = PROD_W - 1;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int MAX_INFLIGHT = QUEUE_DEPTH + 3;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 15;

    localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK_GAIN = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_DELAY_SAMPLES = CFG_IDX_W'(1);

    localparam logic [GAIN_W-1:0]  GAIN_RESET  = GAIN_W'(16384);
    localparam logic [DELAY_W-1:0] DELAY_RESET = DELAY_W'(1024);

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

    typedef struct packed {
        logic [GAIN_W-1:0]  gain;
        logic [DELAY_W-1:0] delay;
    } t_fcf_cfg;

    // Queued work: dry term (1-alpha)*x and the frame-end flag.
    typedef struct packed {
        logic signed [ACC_W-1:0] dry;
        logic                    last;
    } t_fcf_item;

endpackage

### rtl/core/fcf_ram.sv
// ----------------------------------------------------------------------------
// fcf_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module fcf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read returns old contents on a same-address collision
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/fcf_front.sv
// ----------------------------------------------------------------------------
// fcf_front
// Accepts input beats and forms the dry term (1-alpha)*x.
// ----------------------------------------------------------------------------
module fcf_front
    import fcf_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_fcf_cfg                   i_cfg,
    input  logic                       i_s_tvalid,
    output logic                       o_s_tready,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic                       i_last,
    input  logic                       i_q_full,
    output logic                       o_push,
    output t_fcf_item                  o_item
);

    logic                       r_valid;
    t_fcf_item                  r_item;
    logic                       n_valid;
    logic [GAIN_W:0]            one_minus;
    logic signed [PROD_W-1:0]   prod;
    logic                       accept;

    assign one_minus = (GAIN_W+1)'(GAIN_ONE) - {1'b0, i_cfg.gain};
    assign prod      = i_sample * $signed({1'b0, one_minus});

    assign o_push     = r_valid && !i_q_full;
    assign o_s_tready = !r_valid || !i_q_full;
    assign accept     = i_s_tvalid && o_s_tready;
    assign o_item     = r_item;

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (o_push) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.dry  <= prod[ACC_W-1:0];
            r_item.last <= i_last;
        end
    end

endmodule

### rtl/core/fcf_queue.sv
// ----------------------------------------------------------------------------
// fcf_queue
// Short flop-based FIFO between the front and back halves.
// ----------------------------------------------------------------------------
module fcf_queue
    import fcf_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_fcf_item i_item,
    output logic      o_full,
    output logic      o_valid,
    input  logic      i_pop,
    output t_fcf_item o_item
);

    t_fcf_item           r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr;
    logic [QPTR_W:0]     r_count;
    logic [QPTR_W:0]     n_count;
    logic                do_push;
    logic                do_pop;

    assign o_full  = (r_count == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;
    assign o_item  = r_slot[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        case ({do_push, do_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_item;
        end
    end

endmodule

### rtl/core/fcf_back.sv
// ----------------------------------------------------------------------------
// fcf_back
// Delay-line read, feedback multiply-add, saturation and output register.
// ----------------------------------------------------------------------------
module fcf_back
    import fcf_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_fcf_cfg                   i_cfg,
    input  logic                       i_q_valid,
    input  t_fcf_item                  i_q_item,
    output logic                       o_pop,
    output logic                       o_m_tvalid,
    input  logic                       i_m_tready,
    output logic signed [SAMPLE_W-1:0] o_sample,
    output logic                       o_last
);

    // issue side
    logic [PTR_W-1:0]   r_iss_ptr;
    logic               r_wrapped;
    logic [DELAY_W-1:0] d_eff;
    logic [PTR_W-1:0]   rd_addr;
    logic               rd_written;
    logic               rd_adjacent;

    // execute stage
    logic               r_x_valid;
    t_fcf_item          r_x_item;
    logic [PTR_W-1:0]   r_x_ptr;
    logic               r_x_written;
    logic               r_x_adjacent;
    logic               n_x_valid;
    logic               fire;

    logic signed [SAMPLE_W-1:0] ram_q;
    logic signed [SAMPLE_W-1:0] past;
    logic signed [PROD_W-1:0]   wet;
    logic signed [PROD_W-1:0]   acc;
    logic signed [PROD_W-1:0]   shifted;
    logic signed [SAMPLE_W-1:0] y;
    logic signed [SAMPLE_W-1:0] r_last_y;

    // output register
    logic                       r_o_valid;
    logic                       n_o_valid;
    logic signed [SAMPLE_W-1:0] r_o_sample;
    logic                       r_o_last;

    // zero delay acts as one, anything past the line length as the full line
    always_comb begin
        if (i_cfg.delay == '0) begin
            d_eff = DELAY_W'(1);
        end else if (i_cfg.delay > DELAY_W'(MAX_DELAY)) begin
            d_eff = DELAY_W'(MAX_DELAY);
        end else begin
            d_eff = i_cfg.delay;
        end
    end

    assign rd_addr     = r_iss_ptr - d_eff[PTR_W-1:0];
    assign rd_written  = r_wrapped || (d_eff <= {1'b0, r_iss_ptr});
    assign rd_adjacent = (d_eff == DELAY_W'(1));

    assign fire  = r_x_valid && (!r_o_valid || i_m_tready);
    assign o_pop = i_q_valid && (!r_x_valid || fire);

    fcf_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_DELAY)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (fire),
        .i_waddr (r_x_ptr),
        .i_wdata (y),
        .i_re    (o_pop),
        .i_raddr (rd_addr),
        .o_rdata (ram_q)
    );

    // previous result comes from r_last_y, not the line, when D is one
    always_comb begin
        if (r_x_adjacent) begin
            past = r_last_y;
        end else if (r_x_written) begin
            past = ram_q;
        end else begin
            past = '0;
        end
    end

    assign wet     = $signed({1'b0, i_cfg.gain}) * past;
    assign acc     = wet + $signed({r_x_item.dry[ACC_W-1], r_x_item.dry});
    assign shifted = acc >>> GAIN_SHIFT;

    always_comb begin
        if ((&shifted[PROD_W-1:SAMPLE_W-1]) || !(|shifted[PROD_W-1:SAMPLE_W-1])) begin
            y = shifted[SAMPLE_W-1:0];
        end else if (shifted[PROD_W-1]) begin
            y = SAMPLE_MIN;
        end else begin
            y = SAMPLE_MAX;
        end
    end

    always_comb begin
        n_x_valid = r_x_valid;
        if (o_pop) begin
            n_x_valid = 1'b1;
        end else if (fire) begin
            n_x_valid = 1'b0;
        end
        n_o_valid = r_o_valid;
        if (fire) begin
            n_o_valid = 1'b1;
        end else if (i_m_tready) begin
            n_o_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iss_ptr <= '0;
            r_wrapped <= 1'b0;
            r_x_valid <= 1'b0;
            r_o_valid <= 1'b0;
            r_last_y  <= '0;
        end else begin
            r_x_valid <= n_x_valid;
            r_o_valid <= n_o_valid;
            if (o_pop) begin
                r_iss_ptr <= r_iss_ptr + 1'b1;
                if (&r_iss_ptr) begin
                    r_wrapped <= 1'b1;
                end
            end
            if (fire) begin
                r_last_y <= y;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_x_item     <= i_q_item;
            r_x_ptr      <= r_iss_ptr;
            r_x_written  <= rd_written;
            r_x_adjacent <= rd_adjacent;
        end
        if (fire) begin
            r_o_sample <= y;
            r_o_last   <= r_x_item.last;
        end
    end

    assign o_m_tvalid = r_o_valid;
    assign o_sample   = r_o_sample;
    assign o_last     = r_o_last;

endmodule

### rtl/core/feedback_comb_filter_unit.sv
// ----------------------------------------------------------------------------
// feedback_comb_filter_unit
// Beat path: front register, queue, execute stage, output register.
// Throughput: one beat per cycle unless the sink stalls, feedback included.
// Reset (synchronous, active low) empties the pipeline and restores alpha 0.5,
// delay 1024; delay-line slots read before first written return zero.
// ----------------------------------------------------------------------------
// Feedback comb (echo) filter: y[n] = alpha*y[n-D] + (1-alpha)*x[n], Q0.15
// alpha, truncated by an arithmetic shift of 15 and saturated.
//
// Structure:
//   front  - takes beats, forms (1-alpha)*x into a register
//   queue  - four-entry FIFO, lets front and back stall independently
//   back   - issues the delay-line read, then adds alpha*y[n-D] and saturates
//            into the output register
//
// The delay line is a 4096 x 16 RAM with registered read. There is no clearing
// pass: an issue pointer plus a wrapped flag tell whether a slot has been
// written since reset, and unwritten slots read as zero. For D of one the
// previous result is taken straight from a holding register.
// ----------------------------------------------------------------------------
module feedback_comb_filter_unit
    import fcf_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration writes
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    // input stream
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [15:0]           i_s_tdata,    // [15:0] sample_in
    input  logic                  i_s_tlast,    // frame_end_in
    // output stream
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [15:0]           o_m_tdata,    // [15:0] sample_out
    output logic                  o_m_tlast     // frame_end_out
);

    t_fcf_cfg  r_cfg;
    t_fcf_item front_item;
    t_fcf_item q_item;
    logic      push;
    logic      q_full;
    logic      q_valid;
    logic      pop;

    logic signed [SAMPLE_W-1:0] out_sample;

    // config registers, to be written only while idle; nothing in the block enforces it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain  <= GAIN_RESET;
            r_cfg.delay <= DELAY_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_FEEDBACK_GAIN: r_cfg.gain  <= i_cfg_wdata[GAIN_W-1:0];
                CFG_DELAY_SAMPLES: r_cfg.delay <= i_cfg_wdata[DELAY_W-1:0];
                default: ;
            endcase
        end
    end

    fcf_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sample   ($signed(i_s_tdata[SAMPLE_W-1:0])),
        .i_last     (i_s_tlast),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_item     (front_item)
    );

    fcf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (pop),
        .o_item  (q_item)
    );

    fcf_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_q_valid  (q_valid),
        .i_q_item   (q_item),
        .o_pop      (pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_sample   (out_sample),
        .o_last     (o_m_tlast)
    );

    assign o_m_tdata = out_sample;

endmodule

### rtl/core/fcf_checker.sv
// ----------------------------------------------------------------------------
// fcf_checker
// Port-level checks of the comb filter, bound to the top level.
// ----------------------------------------------------------------------------
`include "feedback_comb_filter_unit_assert.svh"

module fcf_checker
    import fcf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        o_s_tready,
    input  logic        o_m_tvalid,
    input  logic        i_m_tready,
    input  logic [15:0] o_m_tdata,
    input  logic        o_m_tlast
);

    localparam int CNT_W = $clog2(MAX_INFLIGHT + 1) + 1;

    logic [CNT_W-1:0] r_inflight;
    logic [CNT_W-1:0] n_inflight;
    logic             in_beat;
    logic             out_beat;

    assign in_beat  = i_s_tvalid && o_s_tready;
    assign out_beat = o_m_tvalid && i_m_tready;

    always_comb begin
        n_inflight = r_inflight;
        case ({in_beat, out_beat})
            2'b10:   n_inflight = r_inflight + 1'b1;
            2'b01:   n_inflight = r_inflight - 1'b1;
            default: n_inflight = r_inflight;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else begin
            r_inflight <= n_inflight;
        end
    end

    // no result without a sample inside
    `FCF_ASSERT_IMP(a_no_phantom, i_clk, i_rst_n, r_inflight == '0, !o_m_tvalid)
    // empty block always takes a beat
    `FCF_ASSERT_IMP(a_idle_ready, i_clk, i_rst_n, r_inflight == '0, o_s_tready)
    // storage bounds the samples held
    `FCF_ASSERT_IMP(a_bounded, i_clk, i_rst_n, 1'b1, r_inflight <= CNT_W'(MAX_INFLIGHT))
    // stalled result holds
    `FCF_ASSERT_NXT(a_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready,
                    o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast))

endmodule

bind feedback_comb_filter_unit fcf_checker u_fcf_checker (.*);

### sim/feedback_comb_filter_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Feedback comb filter unit testbench
// Streams audio beats through the echo filter with random idling on both
// sides. Alpha and delay are changed between bursts. Every output beat is
// checked against a scripted value or the bench's bit-true echo model.
// ----------------------------------------------------------------------------
module feedback_comb_filter_unit_test;
    import fcf_pkg::*;

    localparam int RANDOM_BEATS = 1150;
    localparam int HOLD_CYCLES  = 300;   // long sink stall, fills the pipeline
    localparam int N_ROWS       = 32;

    // one sample beat, either side of the filter
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
    } t_audio_beat;

    typedef enum logic {ROW_SAMPLE, ROW_WRITE} t_row_kind;

    // directed script row: either a register write or a sample beat
    typedef struct packed {
        t_row_kind                  kind;
        logic [CFG_IDX_W-1:0]       reg_idx;
        logic [CFG_DATA_W-1:0]      reg_val;
        logic signed [SAMPLE_W-1:0] x;
        logic                       last;
        logic                       known;  // y below is the expected output
        logic signed [SAMPLE_W-1:0] y;
    } t_script_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_addr;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;
    logic                  i_s_tvalid;
    logic                  o_s_tready;
    logic [15:0]           i_s_tdata;    // [15:0] sample_in
    logic                  i_s_tlast;    // frame_end_in
    logic                  o_m_tvalid;
    logic                  i_m_tready;
    logic [15:0]           o_m_tdata;    // [15:0] sample_out
    logic                  o_m_tlast;    // frame_end_out

    // echo model state, mirrors the block's registers and delay line
    logic signed [SAMPLE_W-1:0] echo_line [MAX_DELAY];
    logic [PTR_W-1:0]           echo_wr_ptr;
    logic [GAIN_W-1:0]          gain_q15;
    logic [DELAY_W-1:0]         delay_len;

    t_audio_beat pending_out [$];   // expected output beats, oldest first
    int          mismatch_count;
    logic        calm;              // no idling on either side
    int          hold_req;          // bumped by stimulus to ask for a sink stall
    int          hold_ack;

    // Directed part. After reset alpha is one half and the first 1024 taps
    // read zero, so y = floor(x/2). Alpha zero passes x straight through.
    // Full alpha with an unwritten tap gives floor(x/32768).
    t_script_row script [N_ROWS] = '{
        '{ROW_SAMPLE, CFG_FEEDBACK_GAIN, 15'd0,     16'sd0,     1'b0, 1'b1, 16'sd0},
        '{ROW_SAMPLE, CFG_FEEDBACK_GAIN, 15'd0,     16'sh7fff,  1'b0, 1'b1, 16'sd16383},
        '{ROW_SAMPLE, CFG_FEEDBACK_GAIN, 15'd0,     16'sh8000,  1'b0, 1'b1, -16'sd16384},
        '{ROW_SAMPLE, CFG_FEEDBACK_GAIN, 15'd0,     16'sd1,     1'b0, 1'b1, 16'sd0},
        '{ROW_SAMPLE, CFG_FEEDBACK_GAIN, 15'd0,     -16'sd1,    1'b1, 1'b1, -16'sd1},
        // alpha zero: dry path only
        '{ROW_WRITE,  CFG_FEEDBACK_GAIN, 15'd0,     16'sd0,     1'b0, 1'b0, 16'sd0},
        '{ROW_SAMPLE, CFG_FEEDBACK_GAIN, 15'd0,     16'sh7fff,  1'b1, 1'b1, 16'sh7fff},
        '{ROW_SAMPLE, CFG_FEEDBACK_GAIN, 15'd0,     16'sh8000,  1'b0, 1'b1, 16'sh8000},
        '{ROW_SAMPLE, CFG_FEEDBACK_GAIN, 15'd0,     16'sh5a5a,  1'b0, 1'b1, 16'sh5a5a},
        // full alpha, shortest delay: feedback from the previous result
        '{ROW_WRITE,  CFG_FEEDBACK_GAIN, 15'd32767, 16'sd0,     1'b0, 1'b0, 16'sd0},
        '{ROW_WRITE,  CFG_DELAY_SAMPLES, 15'd1,     16'sd0,     1'b0, 1'b0, 16'sd0},
        '{ROW_SAMPLE, CFG_FEEDBACK_GAIN, 15'd0,     16'sh8000,  1'b0, 1'b0, 16'sd0},
        '{ROW_SAMPLE, CFG_FEEDBACK_GAIN, 15'd0,     16'sh8000,  1'b0, 1'b0, 16'sd0},
        '{ROW_SAMPLE, CFG_FEEDBACK_GAIN, 15'd0,     16'sh7fff,  1'b1, 1'b0, 16'sd0},
        // delay of zero behaves as one
        '{ROW_WRITE,  CFG_DELAY_SAMPLES, 15'd0,     16'sd0,     1'b0, 1'b0, 16'sd0},
        '{ROW_SAMPLE, CFG_FEEDBACK_GAIN, 15'd0,     16'sh7fff,  1'b0, 1'b0, 16'sd0},
        '{ROW_SAMPLE, CFG_FEEDBACK_GAIN, 15'd0,     16'sh8000,  1'b0, 1'b0, 16'sd0},
        // delay above the line length clamps to it; the tap is still unwritten
        '{ROW_WRITE,  CFG_DELAY_SAMPLES, 15'd8191,  16'sd0,     1'b0, 1'b0, 16'sd0},
        '{ROW_SAMPLE, CFG_FEEDBACK_GAIN, 15'd0,     -16'sd1,    1'b0, 1'b1, -16'sd1},
        '{ROW_SAMPLE, CFG_FEEDBACK_GAIN, 15'd0,     16'sh7fff,  1'b1, 1'b1, 16'sd0},
        '{ROW_WRITE,  CFG_DELAY_SAMPLES, 15'd4096,  16'sd0,     1'b0, 1'b0, 16'sd0},
        '{ROW_SAMPLE, CFG_FEEDBACK_GAIN, 15'd0,     16'sh8000,  1'b0, 1'b1, -16'sd1},
        // tiny alpha, delay two
        '{ROW_WRITE,  CFG_FEEDBACK_GAIN, 15'd1,     16'sd0,     1'b0, 1'b0, 16'sd0},
        '{ROW_WRITE,  CFG_DELAY_SAMPLES, 15'd2,     16'sd0,     1'b0, 1'b0, 16'sd0},
        '{ROW_SAMPLE, CFG_FEEDBACK_GAIN, 15'd0,     16'sd12345, 1'b0, 1'b0, 16'sd0},
        '{ROW_SAMPLE, CFG_FEEDBACK_GAIN, 15'd0,     -16'sd12345,1'b0, 1'b0, 16'sd0},
        '{ROW_SAMPLE, CFG_FEEDBACK_GAIN, 15'd0,     16'sh7fff,  1'b0, 1'b0, 16'sd0},
        '{ROW_SAMPLE, CFG_FEEDBACK_GAIN, 15'd0,     16'sh8000,  1'b1, 1'b0, 16'sd0},
        '{ROW_WRITE,  CFG_FEEDBACK_GAIN, 15'd16384, 16'sd0,     1'b0, 1'b0, 16'sd0},
        '{ROW_WRITE,  CFG_DELAY_SAMPLES, 15'd3,     16'sd0,     1'b0, 1'b0, 16'sd0},
        '{ROW_SAMPLE, CFG_FEEDBACK_GAIN, 15'd0,     16'sh7fff,  1'b0, 1'b0, 16'sd0},
        '{ROW_SAMPLE, CFG_FEEDBACK_GAIN, 15'd0,     16'sh8000,  1'b0, 1'b0, 16'sd0}
    };

    feedback_comb_filter_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // y = alpha*y[n-D] + (1-alpha)*x, floored by the shift, then clamped.
    // Updates the model's delay line and write pointer.
    function automatic t_audio_beat echo_predict(input t_audio_beat din);
        int               span;
        logic [PTR_W-1:0] tap;
        longint           acc;
        longint           y;
        t_audio_beat      dout;
        span = int'(delay_len);
        if (span == 0) span = 1;
        if (span > MAX_DELAY) span = MAX_DELAY;
        tap = echo_wr_ptr - PTR_W'(span);   // span of MAX_DELAY wraps to own slot
        acc = longint'(gain_q15) * longint'(echo_line[tap])
            + longint'(GAIN_ONE - int'(gain_q15)) * longint'($signed(din.sample));
        y = acc >>> GAIN_SHIFT;
        if (y > longint'(SAMPLE_MAX)) y = longint'(SAMPLE_MAX);
        if (y < longint'(SAMPLE_MIN)) y = longint'(SAMPLE_MIN);
        echo_line[echo_wr_ptr] = y[SAMPLE_W-1:0];
        echo_wr_ptr = echo_wr_ptr + 1'b1;
        dout.sample = y[SAMPLE_W-1:0];
        dout.last   = din.last;
        return dout;
    endfunction

    // Present one beat, hold it until taken, then log what should come out.
    task automatic offer_sample(input t_audio_beat b, input logic known,
                                input logic signed [SAMPLE_W-1:0] y_known);
        t_audio_beat want;
        if (!calm && $urandom_range(0, 99) < 20) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b.sample;
        i_s_tlast  <= b.last;
        do @(posedge i_clk); while (!o_s_tready);
        want = echo_predict(b);
        if (known) want.sample = y_known;
        pending_out.push_back(want);
    endtask

    // Register write, only once the pipeline has drained.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        i_s_tvalid <= 1'b0;
        while (pending_out.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_FEEDBACK_GAIN)
            gain_q15 = val[GAIN_W-1:0];
        else
            delay_len = val[DELAY_W-1:0];
    endtask

    // Sink: random back-pressure, plus one long stall on request
    initial begin
        int hold_left;
        hold_left  = 0;
        hold_ack   = 0;
        i_m_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else if (hold_req != hold_ack) begin
                hold_ack   = hold_req;
                hold_left  = HOLD_CYCLES;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= calm || ($urandom_range(0, 99) >= 30);
            end
        end
    end

    // Output checker: each beat against the oldest expectation
    always @(posedge i_clk) begin
        t_audio_beat want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_out.size() == 0) begin
                $error("unexpected output beat: sample_out %0d, frame_end_out %0b",
                       $signed(o_m_tdata), o_m_tlast);
                mismatch_count++;
            end else begin
                want = pending_out.pop_front();
                if (o_m_tdata !== want.sample) begin
                    $error("sample_out: expected %0d, got %0d",
                           want.sample, $signed(o_m_tdata));
                    mismatch_count++;
                end
                if (o_m_tlast !== want.last) begin
                    $error("frame_end_out: expected %0b, got %0b", want.last, o_m_tlast);
                    mismatch_count++;
                end
            end
        end
    end

    // Stimulus
    initial begin
        t_audio_beat        b;
        int                 beats_sent;
        int                 phase;
        int                 burst;
        int                 gain_pick;
        logic [DELAY_W-1:0] dly;

        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_addr     = CFG_FEEDBACK_GAIN;
        i_cfg_wdata    = '0;
        i_s_tvalid     = 1'b0;
        i_s_tdata      = '0;
        i_s_tlast      = 1'b0;
        calm           = 1'b0;
        hold_req       = 0;
        mismatch_count = 0;
        foreach (echo_line[a]) echo_line[a] = '0;
        echo_wr_ptr = '0;
        gain_q15    = GAIN_RESET;
        delay_len   = DELAY_RESET;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (script[r]) begin
            if (script[r].kind == ROW_WRITE) begin
                write_reg(script[r].reg_idx, script[r].reg_val);
            end else begin
                b.sample = script[r].x;
                b.last   = script[r].last;
                offer_sample(b, script[r].known, script[r].y);
            end
        end

        // Random bursts, each under a fresh alpha and delay. Delays are mostly
        // short so the feedback path recirculates; the top two bits of the
        // delay write are junk and must be ignored.
        beats_sent = 0;
        phase      = 0;
        while (beats_sent < RANDOM_BEATS) begin
            case ($urandom_range(0, 5))
                0:       gain_pick = 0;
                1:       gain_pick = 32767;
                default: gain_pick = $urandom_range(0, 32767);
            endcase
            case ($urandom_range(0, 9))
                0:       dly = '0;
                1:       dly = DELAY_W'($urandom_range(MAX_DELAY + 1, 8191));
                2:       dly = DELAY_W'(MAX_DELAY);
                3, 4, 5: dly = DELAY_W'($urandom_range(1, 8));
                6, 7:    dly = DELAY_W'($urandom_range(9, 200));
                default: dly = DELAY_W'($urandom_range(201, MAX_DELAY - 1));
            endcase
            write_reg(CFG_FEEDBACK_GAIN, CFG_DATA_W'(gain_pick));
            write_reg(CFG_DELAY_SAMPLES, {2'($urandom_range(0, 3)), dly});
            calm  <= (phase == 2);
            burst = (phase == 2) ? 150 : $urandom_range(40, 120);
            for (int k = 0; k < burst; k++) begin
                // sink stalls for a long while; source keeps pushing
                if (phase == 4 && k == 8) hold_req <= hold_req + 1;
                case ($urandom_range(0, 7))
                    0:       b.sample = SAMPLE_MAX;
                    1:       b.sample = SAMPLE_MIN;
                    2:       b.sample = SAMPLE_W'(int'($urandom_range(0, 63)) - 32);
                    default: b.sample = SAMPLE_W'($urandom);
                endcase
                b.last = ($urandom_range(0, 7) == 0);
                offer_sample(b, 1'b0, '0);
            end
            beats_sent += burst;
            phase++;
        end

        i_s_tvalid <= 1'b0;
        while (pending_out.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run
    initial begin
        #5000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

### files.f
+incdir+rtl/core
rtl/core/fcf_pkg.sv
rtl/core/fcf_ram.sv
rtl/core/fcf_front.sv
rtl/core/fcf_queue.sv
rtl/core/fcf_back.sv
rtl/core/feedback_comb_filter_unit.sv
rtl/core/fcf_checker.sv
sim/feedback_comb_filter_unit_test.sv
